FILE: design/fpp_pkg.sv
package fpp_pkg;

	// Default display geometry
	localparam int FPP_COLUMNS = 84;
	localparam int FPP_ROWS    = 48;

	// Rows per page and page index width (ROWS must not exceed 64, which the design does not enforce; 8 pages at most)
	localparam int PAGE_ROWS = 8;
	localparam int PAGE_W    = 3;

	// Controller command bases
	localparam logic [7:0] CMD_SET_COL  = 8'h80;
	localparam logic [7:0] CMD_SET_PAGE = 8'h40;

	// Pixel operation codes
	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_SET    = 2'd1,
		MODE_TOGGLE = 2'd2,
		MODE_KEEP   = 2'd3
	} pix_mode_t;

	// Access strobes from the sequencer to the frame store
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

FILE: design/fpp_store.sv
module fpp_store
	import fpp_pkg::*;
#(
	parameter int DEPTH  = FPP_COLUMNS * ((FPP_ROWS + 7) / 8),
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_ctl_t          ctl,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	output logic              ready
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	logic [7:0]        mem [DEPTH];
	logic [7:0]        rd_data_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [7:0]        wd;

	// Clearing sweep after reset: one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Single write port shared by the sweep and the sequencer
	always_comb begin
		we = clr_busy_q | ctl.wr_en;
		wa = clr_busy_q ? clr_addr_q : wr_addr;
		wd = clr_busy_q ? 8'h00 : wr_data;
	end

	// Storage array, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = ~clr_busy_q;

endmodule

FILE: design/framebuffer_pixel_plotter_unit.sv
// Pixel writer for a page-organised monochrome LCD. Each request (x_pos, y_pos, pixel_mode)
// read-modify-writes one byte of an on-chip frame store (COLUMNS x ceil(ROWS/8) bytes, bit 0
// the top row of a page) and then sends three controller bytes: set-column (0x80|x),
// set-page (0x40|page) and the updated data byte, flagged in tuser and marked with tlast.
// Requests outside the display are consumed and give no output. One request is in flight
// at a time: an in-range request passes through accept and read issue, read return with
// modify and write back, and the three output bytes, which wait on any output stall; the
// registered read of the frame store and the three-byte output sequence set these steps.
// After reset the store is cleared by a sweep over all COLUMNS*ceil(ROWS/8) entries (504
// by default), during which no request is accepted.
module framebuffer_pixel_plotter_unit
	import fpp_pkg::*;
#(
	parameter int COLUMNS = FPP_COLUMNS,
	parameter int ROWS    = FPP_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // x_pos[7:0], y_pos[15:8], pixel_mode[17:16], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // lcd_byte[7:0]
	output logic [0:0]  m_axis_tuser,  // is_data[0]
	output logic        m_axis_tlast
);

	localparam int PAGES      = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int STORE_SIZE = COLUMNS * PAGES;
	localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_COL,
		PH_PAGE,
		PH_DATA
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [7:0]        col_q;
	logic [PAGE_W-1:0] page_q;
	logic [2:0]        bit_q;
	pix_mode_t         mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        byte_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_user_q;
	logic              out_last_q;

	logic [7:0]        in_x;
	logic [7:0]        in_y;
	pix_mode_t         in_mode;
	logic [PAGE_W-1:0] in_page;
	logic              in_range;
	logic              in_acc;
	logic [ADDR_W-1:0] in_addr;
	logic              store_ready;
	logic [7:0]        rd_byte;
	logic [7:0]        mask;
	logic [7:0]        new_byte;
	mem_ctl_t          mem_ctl;

	// Unpack and range-check the request
	always_comb begin
		in_x     = s_axis_tdata[7:0];
		in_y     = s_axis_tdata[15:8];
		in_mode  = pix_mode_t'(s_axis_tdata[17:16]);
		in_page  = in_y[PAGE_W+2:3];
		in_range = ({1'b0, in_x} < 9'(COLUMNS)) && ({1'b0, in_y} < 9'(ROWS));
		in_addr  = ADDR_W'(in_page) * ADDR_W'(COLUMNS) + ADDR_W'(in_x);
	end

	assign s_axis_tready = (state_q == ST_IDLE) && store_ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Read on accept, write back on read return; one request in flight, so no overlap
	always_comb begin
		mem_ctl.rd_en = in_acc && in_range;
		mem_ctl.wr_en = (state_q == ST_READ);
	end

	// Bit update
	always_comb begin
		mask = 8'h01 << bit_q;
		case (mode_q)
			MODE_CLEAR:  new_byte = rd_byte & ~mask;
			MODE_SET:    new_byte = rd_byte | mask;
			MODE_TOGGLE: new_byte = rd_byte ^ mask;
			default:     new_byte = rd_byte;
		endcase
	end

	fpp_store #(
		.DEPTH  (STORE_SIZE),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_addr (in_addr),
		.rd_data (rd_byte),
		.wr_addr (addr_q),
		.wr_data (new_byte),
		.ready   (store_ready)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_COL;
			col_q       <= '0;
			page_q      <= '0;
			bit_q       <= '0;
			mode_q      <= MODE_CLEAR;
			addr_q      <= '0;
			byte_q      <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_range) begin
						col_q   <= in_x;
						page_q  <= in_page;
						bit_q   <= in_y[2:0];
						mode_q  <= in_mode;
						addr_q  <= in_addr;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					byte_q      <= new_byte;
					out_valid_q <= 1'b1;
					out_data_q  <= CMD_SET_COL | col_q;
					out_user_q  <= 1'b0;
					out_last_q  <= 1'b0;
					phase_q     <= PH_COL;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						unique case (phase_q)
							PH_COL: begin
								out_data_q <= CMD_SET_PAGE | 8'(page_q);
								phase_q    <= PH_PAGE;
							end
							PH_PAGE: begin
								out_data_q <= byte_q;
								out_user_q <= 1'b1;
								out_last_q <= 1'b1;
								phase_q    <= PH_DATA;
							end
							PH_DATA: begin
								out_valid_q <= 1'b0;
								out_user_q  <= 1'b0;
								out_last_q  <= 1'b0;
								phase_q     <= PH_COL;
								state_q     <= ST_IDLE;
							end
							default: begin
								phase_q <= PH_COL;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;
	assign m_axis_tlast    = out_last_q;

	// No new request while bytes of the previous one are still pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !m_axis_tvalid)
		else $error("request accepted while output pending");

	// Every store read is written back on the following cycle
	a_rmw_pair: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |=> mem_ctl.wr_en)
		else $error("read without write-back");

	// No requests during the clearing sweep
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !s_axis_tready)
		else $error("request taken while store clearing");

	// The last byte of a run is always a data byte
	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("tlast on a command byte");

	// Output run starts in the cycle after the write-back
	a_emit_after_wr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |=> m_axis_tvalid && !m_axis_tuser[0])
		else $error("column command not presented after write-back");

endmodule

FILE: bench/framebuffer_pixel_plotter_unit_tb.sv
module framebuffer_pixel_plotter_unit_tb
	import fpp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_COUNT  = (FPP_ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int FRAME_BYTES = FPP_COLUMNS * PAGE_COUNT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	// One pixel request as presented on the slave side
	typedef struct {
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		pix_mode_t  pixel_mode;
	} pixel_req_t;

	// One byte as it should leave towards the controller
	typedef struct {
		logic [7:0] lcd_byte;
		logic       is_data;
		logic       last_byte;
	} ctl_byte_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;  // x_pos[7:0], y_pos[15:8], pixel_mode[17:16], zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // lcd_byte[7:0]
	logic [0:0]  m_axis_tuser;        // is_data[0]
	logic        m_axis_tlast;

	pixel_req_t  pending_pixels[$];
	ctl_byte_t   expected_bytes[$];
	logic [7:0]  frame_copy [FRAME_BYTES];

	pixel_req_t  next_req;
	ctl_byte_t   want_byte;
	int          pixels_queued = 0;
	int          pixels_taken  = 0;
	int          mismatch_count = 0;
	int          cycle_count   = 0;
	int          send_gap      = 0;
	int          stall_left    = 0;
	bit          calm          = 1'b0;

	framebuffer_pixel_plotter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// Read-modify-write of the local frame copy, then the three controller bytes
	function automatic void plot_pixel(logic [7:0] x, logic [7:0] y, pix_mode_t mode);
		int         page;
		int         idx;
		logic [7:0] mask;
		logic [7:0] pix_byte;
		ctl_byte_t  cb;
		if (x >= FPP_COLUMNS || y >= FPP_ROWS)
			return;
		page = y / PAGE_ROWS;
		idx = page * FPP_COLUMNS + x;
		mask = 8'h01 << (y % PAGE_ROWS);
		pix_byte = frame_copy[idx];
		case (mode)
			MODE_CLEAR:  pix_byte = pix_byte & ~mask;
			MODE_SET:    pix_byte = pix_byte | mask;
			MODE_TOGGLE: pix_byte = pix_byte ^ mask;
			default:     pix_byte = pix_byte;
		endcase
		frame_copy[idx] = pix_byte;
		cb.lcd_byte = CMD_SET_COL | x;
		cb.is_data = 1'b0;
		cb.last_byte = 1'b0;
		expected_bytes.push_back(cb);
		cb.lcd_byte = CMD_SET_PAGE | 8'(page);
		expected_bytes.push_back(cb);
		cb.lcd_byte = pix_byte;
		cb.is_data = 1'b1;
		cb.last_byte = 1'b1;
		expected_bytes.push_back(cb);
	endfunction

	function automatic void queue_pixel(int x, int y, pix_mode_t mode);
		pixel_req_t req;
		req.x_pos = 8'(x);
		req.y_pos = 8'(y);
		req.pixel_mode = mode;
		pending_pixels.push_back(req);
		pixels_queued++;
	endfunction

	// Random request; returns 1 when it lands on the display
	function automatic bit queue_random_pixel();
		int        x;
		int        y;
		pix_mode_t mode;
		mode = pix_mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 85) begin
			// half of the hits go to a small corner so bytes build up
			if ($urandom_range(0, 1)) begin
				x = $urandom_range(0, 7);
				y = $urandom_range(0, 15);
			end else begin
				x = $urandom_range(0, FPP_COLUMNS - 1);
				y = $urandom_range(0, FPP_ROWS - 1);
			end
			queue_pixel(x, y, mode);
			return 1'b1;
		end
		if ($urandom_range(0, 1)) begin
			x = $urandom_range(FPP_COLUMNS, 255);
			y = $urandom_range(0, 255);
		end else begin
			x = $urandom_range(0, 255);
			y = $urandom_range(FPP_ROWS, 255);
		end
		queue_pixel(x, y, mode);
		return 1'b0;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				plot_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8],
					pix_mode_t'(s_axis_tdata[17:16]));
				pixels_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					next_req = pending_pixels.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'b0, next_req.pixel_mode, next_req.y_pos, next_req.x_pos};
					send_gap <= calm ? 0 : idle_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and sink back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h user %0b last %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want_byte = expected_bytes.pop_front();
					if (m_axis_tdata !== want_byte.lcd_byte)
						report_mismatch($sformatf("lcd_byte %02h, expected %02h",
							m_axis_tdata, want_byte.lcd_byte));
					if (m_axis_tuser[0] !== want_byte.is_data)
						report_mismatch($sformatf("is_data %0b, expected %0b (byte %02h)",
							m_axis_tuser[0], want_byte.is_data, want_byte.lcd_byte));
					if (m_axis_tlast !== want_byte.last_byte)
						report_mismatch($sformatf("last_byte %0b, expected %0b (byte %02h)",
							m_axis_tlast, want_byte.last_byte, want_byte.lcd_byte));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= calm ? 0 : idle_gap();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("framebuffer_pixel_plotter_unit_tb NOT OK");
			$finish;
		end
	end

	// Stimulus: directed requests, then random runs with and without idling
	initial begin
		int hits;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame_copy[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// display corners
		queue_pixel(0, 0, MODE_SET);
		queue_pixel(FPP_COLUMNS - 1, 0, MODE_SET);
		queue_pixel(0, FPP_ROWS - 1, MODE_SET);
		queue_pixel(FPP_COLUMNS - 1, FPP_ROWS - 1, MODE_TOGGLE);
		// off the display: column, row, both
		queue_pixel(FPP_COLUMNS, 0, MODE_SET);
		queue_pixel(0, FPP_ROWS, MODE_SET);
		queue_pixel(255, 255, MODE_KEEP);
		queue_pixel(200, 10, MODE_TOGGLE);
		// every mode on one pixel
		queue_pixel(10, 20, MODE_SET);
		queue_pixel(10, 20, MODE_TOGGLE);
		queue_pixel(10, 20, MODE_TOGGLE);
		queue_pixel(10, 20, MODE_CLEAR);
		queue_pixel(10, 20, MODE_KEEP);
		// keep on an untouched byte still sends the run
		queue_pixel(30, 33, MODE_KEEP);
		// fill a whole page byte bit by bit
		for (int r = 8; r < 16; r++)
			queue_pixel(5, r, MODE_SET);

		// calm stretch, then the bulk with idling on both sides
		for (int ph = 0; ph < 3; ph++) begin
			while (pixels_taken != pixels_queued || expected_bytes.size() != 0)
				@(posedge clk);
			calm = (ph == 1);
			hits = 0;
			if (ph != 0)
				while (hits < ((ph == 1) ? 80 : 250))
					hits += queue_random_pixel();
		end

		while (pixels_taken != pixels_queued || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("framebuffer_pixel_plotter_unit_tb OK");
		else
			$display("framebuffer_pixel_plotter_unit_tb NOT OK");
		$finish;
	end

endmodule
